// ===== src/pidl_pkg.sv =====
// Shared types, constants and helpers for the positional insert/delete list.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DELETE = 2'd3
    } req_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_op_t             req_type;
        logic [POS_W-1:0]    position;
        logic [DATA_W-1:0]   value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        status_t             status;
        logic [LEN_W-1:0]    length;
    } rsp_t;

    // broadcast to every cell in the cycle a request is accepted
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              mod;
        logic [CMP_W-1:0]  pos;
        elem_t             value;
    } cell_cmd_t;

    function automatic elem_t to_elem(logic [DATA_W-1:0] v);
        elem_t r;
        r = '0;
        for (int i = 0; i < ELEM_WIDTH; i++)
        begin
            if (i < DATA_W)
            begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] from_elem(elem_t e);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (i < ELEM_WIDTH)
            begin
                r[i] = e[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== src/pidl_cell.sv =====
// One list slot: holds one element and shifts with its neighbors.
// Depends on pidl_pkg for the command struct and element type.
`timescale 1ns / 1ps

module pidl_cell (
    input  logic                  clk,
    input  pidl_pkg::idx_t        idx,
    input  pidl_pkg::cell_cmd_t   cmd,
    input  pidl_pkg::elem_t       left,
    input  pidl_pkg::elem_t       right,
    output pidl_pkg::elem_t       data
);

    pidl_pkg::elem_t                data_reg;
    pidl_pkg::elem_t                data_next;
    logic [pidl_pkg::CMP_W-1:0]     idx_w;
    logic                           at_pos;
    logic                           above_pos;

    assign idx_w     = pidl_pkg::CMP_W'(idx);
    assign at_pos    = (idx_w == cmd.pos);
    assign above_pos = (idx_w > cmd.pos);

    always_comb
    begin
        priority if (cmd.ins && above_pos)
        begin
            data_next = left;
        end
        else if ((cmd.ins || cmd.mod) && at_pos)
        begin
            data_next = cmd.value;
        end
        else if (cmd.del && (at_pos || above_pos))
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/positional_insert_delete_list.sv =====
// Top level of the positional insert/delete list: request decode, length
// counter, row of pidl_cell slots and response register. Uses pidl_pkg.
//
//   channel   handshake               payload      direction
//   request   req_valid / req_ready   req (req_t)  in
//   response  rsp_valid / rsp_ready   rsp (rsp_t)  out
//
// One request per cycle while req_ready is high: slots update in parallel
// in the accept cycle; the response is registered and shown the next cycle.
// req_ready is high while the response register is empty or being taken.
// Reset clears the length and the response valid; slot contents are
// undefined until written and get no clearing pass.
`timescale 1ns / 1ps

module positional_insert_delete_list (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  pidl_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pidl_pkg::rsp_t  rsp
);

    logic [pidl_pkg::CNT_W-1:0]    count_reg;
    logic [pidl_pkg::CNT_W-1:0]    count_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    pidl_pkg::rsp_t                rsp_reg;
    pidl_pkg::rsp_t                rsp_next;

    logic                          accept;
    pidl_pkg::status_t             status;
    logic [pidl_pkg::CMP_W-1:0]    pos_w;
    logic [pidl_pkg::CMP_W-1:0]    cnt_w;
    logic                          ok;
    pidl_pkg::cell_cmd_t           cmd;
    pidl_pkg::elem_t               slot [pidl_pkg::CAPACITY];
    pidl_pkg::elem_t               rd_elem;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign pos_w     = pidl_pkg::CMP_W'(req.position);
    assign cnt_w     = pidl_pkg::CMP_W'(count_reg);

    always_comb
    begin
        status = pidl_pkg::ST_OK;
        unique case (req.req_type)
            pidl_pkg::OP_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status = pidl_pkg::ST_RANGE;
                end
                else if (count_reg == pidl_pkg::CNT_W'(pidl_pkg::CAPACITY))
                begin
                    status = pidl_pkg::ST_FULL;
                end
            end
            pidl_pkg::OP_READ, pidl_pkg::OP_MODIFY, pidl_pkg::OP_DELETE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = pidl_pkg::ST_RANGE;
                end
            end
        endcase
    end

    assign ok        = (status == pidl_pkg::ST_OK);
    assign cmd.ins   = accept && ok && (req.req_type == pidl_pkg::OP_INSERT);
    assign cmd.del   = accept && ok && (req.req_type == pidl_pkg::OP_DELETE);
    assign cmd.mod   = accept && ok && (req.req_type == pidl_pkg::OP_MODIFY);
    assign cmd.pos   = pos_w;
    assign cmd.value = pidl_pkg::to_elem(req.value);

    genvar g;
    generate
        for (g = 0; g < pidl_pkg::CAPACITY; g++)
        begin : g_cell
            pidl_pkg::elem_t left;
            pidl_pkg::elem_t right;
            if (g == 0)
            begin : g_first
                assign left = '0;
            end
            else
            begin : g_mid_l
                assign left = slot[g-1];
            end
            if (g == pidl_pkg::CAPACITY - 1)
            begin : g_last
                assign right = '0;
            end
            else
            begin : g_mid_r
                assign right = slot[g+1];
            end
            pidl_cell u_cell (
                .clk   (clk),
                .idx   (pidl_pkg::IDX_W'(g)),
                .cmd   (cmd),
                .left  (left),
                .right (right),
                .data  (slot[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_elem = '0;
        for (int i = 0; i < pidl_pkg::CAPACITY; i++)
        begin
            if (pidl_pkg::CMP_W'(i) == pos_w)
            begin
                rd_elem = slot[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = status;
            rsp_next.length     = pidl_pkg::LEN_W'(count_next);
            rsp_next.read_value = (ok && (req.req_type == pidl_pkg::OP_READ))
                                  ? pidl_pkg::from_elem(rd_elem) : '0;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/pidl_checker.sv =====
// Port-level checks for positional_insert_delete_list, bound to the top level.
// Depends on pidl_pkg for the payload types and capacity.
`timescale 1ns / 1ps

module pidl_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  pidl_pkg::rsp_t  rsp
);

    localparam logic [pidl_pkg::LEN_W-1:0] CAP_LEN =
        pidl_pkg::LEN_W'(pidl_pkg::CAPACITY);
    localparam bit CAP_WRAPS = (pidl_pkg::CAPACITY >= (1 << pidl_pkg::LEN_W));

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no response");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !CAP_WRAPS |-> rsp.length <= CAP_LEN)
        else $error("length beyond capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == pidl_pkg::ST_FULL |-> rsp.length == CAP_LEN)
        else $error("full status with list not full");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != pidl_pkg::ST_OK |-> rsp.read_value == '0)
        else $error("failed request returned data");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== verif/tb_positional_insert_delete_list.sv =====
// Self-checking testbench for positional_insert_delete_list: directed table, then random
// fill/drain traffic checked against a shadow list model. Depends on pidl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_positional_insert_delete_list;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int DIR_ROWS = 24;

    typedef struct {
        pidl_pkg::req_op_t  op;
        logic [4:0]         pos;
        logic [31:0]        value;
        int                 reps;
        bit                 typed;
        pidl_pkg::rsp_t     want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    pidl_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    pidl_pkg::rsp_t rsp;

    pidl_pkg::elem_t shadow_elems [pidl_pkg::CAPACITY];
    int              shadow_len = 0;
    pidl_pkg::rsp_t  due_responses [$];

    int send_idle_pct = 22;
    int recv_stall_pct = 57;
    int fail_count = 0;
    int quiet_cycles = 0;

    dir_row_t plan [DIR_ROWS] = '{
        '{pidl_pkg::OP_READ,   5'd0,  32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}},
        '{pidl_pkg::OP_DELETE, 5'd0,  32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}},
        '{pidl_pkg::OP_MODIFY, 5'd0,  32'hFFFF_FFFF, 1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}},
        '{pidl_pkg::OP_INSERT, 5'd1,  32'h1234_5678, 1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}},
        '{pidl_pkg::OP_INSERT, 5'd31, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}},
        '{pidl_pkg::OP_INSERT, 5'd0,  32'hFFFF_FFFF, 1,  1'b1, '{32'h0, pidl_pkg::ST_OK, 5'd1}},
        '{pidl_pkg::OP_INSERT, 5'd1,  32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_OK, 5'd2}},
        '{pidl_pkg::OP_READ,   5'd0,  32'h0,         1,  1'b1,
          '{32'hFFFF_FFFF, pidl_pkg::ST_OK, 5'd2}},
        '{pidl_pkg::OP_INSERT, 5'd1,  32'hA5A5_A5A5, 1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd1,  32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_MODIFY, 5'd2,  32'h5A5A_5A5A, 1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd2,  32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_DELETE, 5'd0,  32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd0,  32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd2,  32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd2}},
        '{pidl_pkg::OP_INSERT, 5'd0,  32'h1000_0000, 14, 1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_INSERT, 5'd16, 32'hDEAD_BEEF, 1,  1'b1, '{32'h0, pidl_pkg::ST_FULL, 5'd16}},
        '{pidl_pkg::OP_INSERT, 5'd17, 32'hDEAD_BEEF, 1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd16}},
        '{pidl_pkg::OP_READ,   5'd15, 32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd16, 32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd16}},
        '{pidl_pkg::OP_DELETE, 5'd15, 32'h0,         1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_INSERT, 5'd15, 32'hFFFF_FFFF, 1,  1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_DELETE, 5'd0,  32'h0,         16, 1'b0, '{32'h0, pidl_pkg::ST_OK, 5'd0}},
        '{pidl_pkg::OP_READ,   5'd0,  32'h0,         1,  1'b1, '{32'h0, pidl_pkg::ST_RANGE, 5'd0}}
    };

    positional_insert_delete_list DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic pidl_pkg::rsp_t apply_list_request(pidl_pkg::req_t r);
        pidl_pkg::rsp_t res;
        int p;
        res = '0;
        res.status = pidl_pkg::ST_OK;
        p = int'(r.position);
        if (r.req_type == pidl_pkg::OP_INSERT)
        begin
            if (p > shadow_len)
            begin
                res.status = pidl_pkg::ST_RANGE;
            end
            else if (shadow_len >= pidl_pkg::CAPACITY)
            begin
                res.status = pidl_pkg::ST_FULL;
            end
            else
            begin
                for (int i = shadow_len; i > p; i--)
                begin
                    shadow_elems[i] = shadow_elems[i-1];
                end
                shadow_elems[p] = pidl_pkg::to_elem(r.value);
                shadow_len++;
            end
        end
        else if (p >= shadow_len)
        begin
            res.status = pidl_pkg::ST_RANGE;
        end
        else if (r.req_type == pidl_pkg::OP_READ)
        begin
            res.read_value = pidl_pkg::from_elem(shadow_elems[p]);
        end
        else if (r.req_type == pidl_pkg::OP_MODIFY)
        begin
            shadow_elems[p] = pidl_pkg::to_elem(r.value);
        end
        else
        begin
            for (int i = p; i + 1 < shadow_len; i++)
            begin
                shadow_elems[i] = shadow_elems[i+1];
            end
            shadow_len--;
        end
        res.length = pidl_pkg::LEN_W'(shadow_len);
        return res;
    endfunction

    task automatic send_request(pidl_pkg::req_t r, bit typed, pidl_pkg::rsp_t want);
        pidl_pkg::rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_list_request(r);
        due_responses.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        pidl_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_responses.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, actual %h",
                             $time, want.read_value, rsp.read_value);
                    fail_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $display("%0t: length mismatch: expected %0d, actual %0d",
                             $time, want.length, rsp.length);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("positional_insert_delete_list test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        pidl_pkg::req_t r;
        bit   draining;
        int   pick;
        draining = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[row])
        begin
            for (int k = 0; k < plan[row].reps; k++)
            begin
                r.req_type = plan[row].op;
                r.position = plan[row].pos;
                r.value = plan[row].value + 32'(k);
                send_request(r, plan[row].typed, plan[row].want);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 22 : 0;
            repeat (RANDOM_PER_PHASE)
            begin
                if (shadow_len >= pidl_pkg::CAPACITY)
                    draining = 1'b1;
                else if (shadow_len == 0)
                    draining = 1'b0;
                pick = $urandom_range(99);
                if (pick < 55)
                    r.req_type = draining ? pidl_pkg::OP_DELETE : pidl_pkg::OP_INSERT;
                else if (pick < 70)
                    r.req_type = pidl_pkg::OP_READ;
                else if (pick < 85)
                    r.req_type = pidl_pkg::OP_MODIFY;
                else
                    r.req_type = draining ? pidl_pkg::OP_INSERT : pidl_pkg::OP_DELETE;
                if ($urandom_range(99) < 15)
                    r.position = pidl_pkg::POS_W'($urandom_range(31));
                else if (r.req_type == pidl_pkg::OP_INSERT)
                    r.position = pidl_pkg::POS_W'($urandom_range(shadow_len));
                else if (shadow_len > 0)
                    r.position = pidl_pkg::POS_W'($urandom_range(shadow_len - 1));
                else
                    r.position = '0;
                pick = $urandom_range(9);
                r.value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                send_request(r, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("positional_insert_delete_list test passed");
        else
            $display("positional_insert_delete_list test failed");
        $finish;
    end

endmodule
